// ===== hdl/p2g_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_pkg
// Shared types and constants of the particle-to-grid scatter block.
// ----------------------------------------------------------------------------
package p2g_pkg;

	// grid and material geometry
	localparam int GRID_X    = 64;
	localparam int GRID_Y    = 64;
	localparam int MATERIALS = 4;
	localparam int NODES     = GRID_X * GRID_Y;
	localparam int NODE_W    = $clog2(NODES);

	// configuration port
	localparam int MASS_REGS = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_W-1:0] MASS_RESET = 16'd256;

	// command codes
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_SCATTER = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// result status codes
	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_DROPPED = 1'b1;

	typedef logic [NODE_W-1:0] node_addr_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [1:0]         material;
		logic [5:0]         node_x;
		logic [5:0]         node_y;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic               node_active;
		logic [47:0]        node_mass;
		logic [47:0]        node_density;
		logic signed [47:0] node_momentum_x;
		logic signed [47:0] node_momentum_y;
		logic signed [31:0] node_grad_x;
		logic signed [31:0] node_grad_y;
	} out_item_t;

	// one grid node as stored in the accumulator memory
	typedef struct packed {
		logic [47:0]                   mass;
		logic [47:0]                   density;
		logic [47:0]                   mom_x;
		logic [47:0]                   mom_y;
		logic [MATERIALS-1:0][31:0]    grad_x;
		logic [MATERIALS-1:0][31:0]    grad_y;
	} node_row_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       issue;
		logic [1:0] ix;
		logic [1:0] jy;
		logic       sweep_we;
		node_addr_t sweep_addr;
		logic       out_load;
		logic       out_read;
		logic       out_status;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop;
		logic busy;
	} dp_status_t;

endpackage

// ===== hdl/p2g_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module p2g_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/p2g_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_datapath
// Weight pipeline, node accumulator memories, mass registers, result register.
// ----------------------------------------------------------------------------
module p2g_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  p2g_pkg::in_item_t                     req,
	input  logic                                  cfg_we,
	input  logic [p2g_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [p2g_pkg::CFG_W-1:0]             cfg_data,
	input  p2g_pkg::ctrl_cmd_t                    cmd,
	output p2g_pkg::dp_status_t                   st,
	output p2g_pkg::out_item_t                    rsp
);

	// magnitude to square for stencil offset k, from the fraction r
	function automatic logic [10:0] axis_mag(input logic [9:0] r, input logic [1:0] k);
		logic [10:0] m;
		case (k)
			2'd0: m = 11'd1024 - {1'b0, r};
			2'd1: m = r[9] ? {2'b0, r[8:0]} : (11'd512 - {1'b0, r});
			default: m = {1'b0, r};
		endcase
		return m;
	endfunction

	// gradient for stencil offset k, Q.10 signed
	function automatic logic signed [11:0] axis_grad(input logic [9:0] r, input logic [1:0] k);
		logic signed [11:0] g;
		case (k)
			2'd0: g = $signed(12'd1024 - {2'b0, r});
			2'd1: g = $signed({1'b0, r, 1'b0}) - 12'sd1024;
			default: g = 12'sd0 - $signed({2'b0, r});
		endcase
		return g;
	endfunction

	// mass registers
	logic [p2g_pkg::CFG_W-1:0] mass_q [p2g_pkg::MASS_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < p2g_pkg::MASS_REGS; k++) begin
				mass_q[k] <= p2g_pkg::MASS_RESET;
			end
		end else if (cfg_we) begin
			mass_q[cfg_index] <= cfg_data;
		end
	end

	// transaction latch
	p2g_pkg::in_item_t req_q;
	logic [15:0]       m_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			m_q   <= mass_q[req.material];
		end
	end

	// base cell and fraction per axis
	logic [15:0] offx, offy;
	logic [5:0]  cx, cy;
	logic [9:0]  rx, ry;
	logic        drop_x, drop_y, drop_mat;

	assign offx = req_q.pos_x - 16'd512;
	assign offy = req_q.pos_y - 16'd512;
	assign cx   = offx[15:10];
	assign cy   = offy[15:10];
	assign rx   = offx[9:0];
	assign ry   = offy[9:0];
	assign drop_x   = (req_q.pos_x < 16'd512) || (int'(cx) + 3 > p2g_pkg::GRID_X);
	assign drop_y   = (req_q.pos_y < 16'd512) || (int'(cy) + 3 > p2g_pkg::GRID_Y);
	assign drop_mat = int'(req_q.material) >= p2g_pkg::MATERIALS;

	assign st.drop = drop_x || drop_y || drop_mat;

	// stage 0 selection
	logic [10:0]         magx, magy;
	logic [21:0]         sqx, sqy;
	logic [20:0]         wx0, wy0;
	p2g_pkg::node_addr_t node_s0;

	assign magx = axis_mag(rx, cmd.ix);
	assign magy = axis_mag(ry, cmd.jy);
	assign sqx  = 22'(magx) * 22'(magx);
	assign sqy  = 22'(magy) * 22'(magy);
	assign wx0  = (cmd.ix == 2'd1) ? (21'd1572864 - 21'({sqx, 1'b0})) : 21'(sqx);
	assign wy0  = (cmd.jy == 2'd1) ? (21'd1572864 - 21'({sqy, 1'b0})) : 21'(sqy);
	assign node_s0 = p2g_pkg::node_addr_t'((int'(cx) + int'(cmd.ix)) * p2g_pkg::GRID_Y
		+ int'(cy) + int'(cmd.jy));

	// pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	p2g_pkg::node_addr_t node_s1, node_s2, node_s3, node_s4, node_s5, node_s6, node_s7;
	logic [20:0]         wx_s1, wy_s1;
	logic signed [11:0]  gx_s1, gy_s1;
	logic [41:0]         wxy_s2;
	logic signed [33:0]  gxw_s2, gyw_s2;
	logic [57:0]         prod_s3;
	logic signed [18:0]  cgx_s3, cgx_s4, cgx_s5, cgx_s6, cgx_s7;
	logic signed [18:0]  cgy_s3, cgy_s4, cgy_s5, cgy_s6, cgy_s7;
	logic [23:0]         phi_s4, phi_s5, phi_s6, phi_s7;
	logic [39:0]         pm_s5;
	logic signed [56:0]  mux_s6, muy_s6;
	logic [31:0]         mc_s6, mc_s7;
	logic signed [38:0]  mu_s7, mv_s7;

	logic signed [33:0] gxw_rnd, gyw_rnd;
	logic [57:0]        prod_rnd;
	logic [39:0]        pm_rnd;
	logic signed [56:0] mux_rnd, muy_rnd;

	assign gxw_rnd  = gxw_s2 + 34'sd16384;
	assign gyw_rnd  = gyw_s2 + 34'sd16384;
	assign prod_rnd = prod_s3 + (58'd1 << 33);
	assign pm_rnd   = pm_s5 + 40'd128;
	assign mux_rnd  = mux_s6 + 57'sd131072;
	assign muy_rnd  = muy_s6 + 57'sd131072;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign st.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7;

	// weight and product stages
	always_ff @(posedge clk) begin
		// stage 1: per-axis weights and gradients
		wx_s1   <= wx0;
		wy_s1   <= wy0;
		gx_s1   <= axis_grad(rx, cmd.ix);
		gy_s1   <= axis_grad(ry, cmd.jy);
		node_s1 <= node_s0;
		// stage 2: weight products
		wxy_s2  <= 42'(wx_s1) * 42'(wy_s1);
		gxw_s2  <= 34'(gx_s1) * $signed({13'b0, wy_s1});
		gyw_s2  <= $signed({13'b0, wx_s1}) * 34'(gy_s1);
		node_s2 <= node_s1;
		// stage 3: times mass, round gradients
		prod_s3 <= 58'(wxy_s2) * 58'(m_q);
		cgx_s3  <= gxw_rnd[33:15];
		cgy_s3  <= gyw_rnd[33:15];
		node_s3 <= node_s2;
		// stage 4: phi rounded to Q.16
		phi_s4  <= prod_rnd[57:34];
		cgx_s4  <= cgx_s3;
		cgy_s4  <= cgy_s3;
		node_s4 <= node_s3;
		// stage 5: phi times mass
		pm_s5   <= 40'(phi_s4) * 40'(m_q);
		phi_s5  <= phi_s4;
		cgx_s5  <= cgx_s4;
		cgy_s5  <= cgy_s4;
		node_s5 <= node_s4;
		// stage 6: momentum products, mass term
		mux_s6  <= $signed({17'b0, pm_s5}) * 57'(req_q.vel_x);
		muy_s6  <= $signed({17'b0, pm_s5}) * 57'(req_q.vel_y);
		mc_s6   <= pm_rnd[39:8];
		phi_s6  <= phi_s5;
		cgx_s6  <= cgx_s5;
		cgy_s6  <= cgy_s5;
		node_s6 <= node_s5;
		// stage 7: momentum rounded, memory data arrives
		mu_s7   <= mux_rnd[56:18];
		mv_s7   <= muy_rnd[56:18];
		mc_s7   <= mc_s6;
		phi_s7  <= phi_s6;
		cgx_s7  <= cgx_s6;
		cgy_s7  <= cgy_s6;
		node_s7 <= node_s6;
	end

	// read node address and range check
	p2g_pkg::node_addr_t rd_node;
	logic                rd_bad;

	assign rd_bad  = (int'(req_q.node_x) >= p2g_pkg::GRID_X)
		|| (int'(req_q.node_y) >= p2g_pkg::GRID_Y);
	assign rd_node = p2g_pkg::node_addr_t'(int'(req_q.node_x) * p2g_pkg::GRID_Y
		+ int'(req_q.node_y));

	// accumulator and touched memories
	p2g_pkg::node_addr_t raddr, taddr;
	p2g_pkg::node_row_t  row_rd, row_wr;
	logic                touched_rd, t_we;

	assign raddr = v_s6 ? node_s6 : rd_node;
	assign t_we  = cmd.sweep_we | v_s7;
	assign taddr = cmd.sweep_we ? cmd.sweep_addr : node_s7;

	p2g_ram #(
		.WIDTH($bits(p2g_pkg::node_row_t)),
		.DEPTH(p2g_pkg::NODES)
	) u_row_ram (
		.clk   (clk),
		.we    (v_s7),
		.waddr (node_s7),
		.wdata (row_wr),
		.raddr (raddr),
		.rdata (row_rd)
	);

	p2g_ram #(
		.WIDTH(1),
		.DEPTH(p2g_pkg::NODES)
	) u_touch_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (taddr),
		.wdata (!cmd.sweep_we),
		.raddr (raddr),
		.rdata (touched_rd)
	);

	// saturating accumulate, first touch starts from zero
	p2g_pkg::node_row_t old_row;
	logic [48:0]        sum_m, sum_d;
	logic signed [48:0] sum_mx, sum_my;
	logic signed [32:0] sum_gx, sum_gy;

	assign old_row = touched_rd ? row_rd : '0;
	assign sum_m   = {1'b0, old_row.mass} + 49'(mc_s7);
	assign sum_d   = {1'b0, old_row.density} + 49'(phi_s7);
	assign sum_mx  = 49'($signed(old_row.mom_x)) + 49'(mu_s7);
	assign sum_my  = 49'($signed(old_row.mom_y)) + 49'(mv_s7);
	assign sum_gx  = 33'($signed(old_row.grad_x[req_q.material])) + 33'(cgx_s7);
	assign sum_gy  = 33'($signed(old_row.grad_y[req_q.material])) + 33'(cgy_s7);

	always_comb begin
		row_wr = old_row;
		row_wr.mass    = sum_m[48] ? {48{1'b1}} : sum_m[47:0];
		row_wr.density = sum_d[48] ? {48{1'b1}} : sum_d[47:0];
		if (sum_mx[48] != sum_mx[47]) begin
			row_wr.mom_x = sum_mx[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end else begin
			row_wr.mom_x = sum_mx[47:0];
		end
		if (sum_my[48] != sum_my[47]) begin
			row_wr.mom_y = sum_my[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end else begin
			row_wr.mom_y = sum_my[47:0];
		end
		if (sum_gx[32] != sum_gx[31]) begin
			row_wr.grad_x[req_q.material] = sum_gx[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end else begin
			row_wr.grad_x[req_q.material] = sum_gx[31:0];
		end
		if (sum_gy[32] != sum_gy[31]) begin
			row_wr.grad_y[req_q.material] = sum_gy[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end else begin
			row_wr.grad_y[req_q.material] = sum_gy[31:0];
		end
	end

	// result register
	logic               rd_active, slot_ok;
	p2g_pkg::out_item_t rsp_d;

	assign rd_active = !rd_bad && touched_rd;
	assign slot_ok   = int'(req_q.material) < p2g_pkg::MATERIALS;

	// next result, all unused fields zero
	always_comb begin
		rsp_d = '0;
		if (cmd.out_read) begin
			rsp_d.status = rd_bad ? p2g_pkg::ST_DROPPED : p2g_pkg::ST_DONE;
			if (rd_active) begin
				rsp_d.node_active     = 1'b1;
				rsp_d.node_mass       = row_rd.mass;
				rsp_d.node_density    = row_rd.density;
				rsp_d.node_momentum_x = row_rd.mom_x;
				rsp_d.node_momentum_y = row_rd.mom_y;
				if (slot_ok) begin
					rsp_d.node_grad_x = row_rd.grad_x[req_q.material];
					rsp_d.node_grad_y = row_rd.grad_y[req_q.material];
				end
			end
		end else begin
			rsp_d.status = cmd.out_status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp <= rsp_d;
		end
	end

endmodule

// ===== hdl/p2g_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_ctrl
// Command sequencer: clear sweep, stencil issue, drain, read, result handoff.
// ----------------------------------------------------------------------------
module p2g_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          req_cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  p2g_pkg::dp_status_t st,
	output p2g_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_SWEEP  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_ISSUE  = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_RDADDR = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]          state_q;
	logic [1:0]          i_q, j_q;
	p2g_pkg::node_addr_t sweep_q;
	logic                reply_q, res_read_q, res_status_q, out_valid_q;
	logic                accept, out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.issue      = (state_q == S_ISSUE);
		cmd.ix         = i_q;
		cmd.jy         = j_q;
		cmd.sweep_we   = (state_q == S_SWEEP);
		cmd.sweep_addr = sweep_q;
		cmd.out_load   = (state_q == S_FINISH) && out_free;
		cmd.out_read   = res_read_q;
		cmd.out_status = res_status_q;
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_q      <= '0;
			reply_q      <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			res_read_q   <= 1'b0;
			res_status_q <= p2g_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == p2g_pkg::node_addr_t'(p2g_pkg::NODES - 1)) begin
						state_q <= reply_q ? S_FINISH : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_read_q   <= (req_cmd == p2g_pkg::CMD_READ);
						res_status_q <= p2g_pkg::ST_DONE;
						case (req_cmd)
							p2g_pkg::CMD_CLEAR: begin
								sweep_q <= '0;
								reply_q <= 1'b1;
								state_q <= S_SWEEP;
							end
							p2g_pkg::CMD_SCATTER: state_q <= S_SETUP;
							p2g_pkg::CMD_READ: state_q <= S_RDADDR;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_SETUP: begin
					i_q <= '0;
					j_q <= '0;
					if (st.drop) begin
						res_status_q <= p2g_pkg::ST_DROPPED;
						state_q      <= S_FINISH;
					end else begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (j_q == 2'd2) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (i_q == 2'd2) begin
							state_q <= S_DRAIN;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!st.busy) begin
						state_q <= S_FINISH;
					end
				end
				S_RDADDR: state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !st.busy)
		else $error("pipeline busy while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp_ready) |=> out_valid_q)
		else $error("result dropped before taken");

	a_no_issue_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_we |-> (!cmd.issue && !st.busy))
		else $error("stencil write during clear sweep");
`endif

endmodule

// ===== hdl/particle_to_grid_scatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_to_grid_scatter
// Quadratic B-spline particle-to-grid scatter with node read-back.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  req      | req_valid, req_ready, req       | in
//  rsp      | rsp_valid, rsp_ready, rsp       | out
//  cfg      | cfg_we, cfg_index, cfg_data     | in
//
//  scatter: setup, nine nodes issued one per cycle through a seven-stage weight
//  pipeline, read-modify-write of the node memory port.
//  read: address state, then result; unused command: straight to result.
//  clear and reset: sweep of all 4096 entries of the touched-mark memory, req_ready low.
//  a waiting result stalls only the next result, not the next transaction.
// ----------------------------------------------------------------------------
module particle_to_grid_scatter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  p2g_pkg::in_item_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output p2g_pkg::out_item_t            rsp,
	input  logic                          cfg_we,
	input  logic [p2g_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2g_pkg::CFG_W-1:0]     cfg_data
);

	p2g_pkg::ctrl_cmd_t  cmd;
	p2g_pkg::dp_status_t st;

	// sequencer
	p2g_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_cmd   (req.cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// arithmetic and storage
	p2g_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.rsp       (rsp)
	);

endmodule
